// ===== hdl/frame_ring_queue_overwrite_defines.svh =====
// ---------------------------------------------------------------------------
// frame ring queue assertion macros
// shared concurrent assertion forms for the frame ring queue checkers
// ---------------------------------------------------------------------------
`ifndef FRAME_RING_QUEUE_OVERWRITE_DEFINES_SVH
`define FRAME_RING_QUEUE_OVERWRITE_DEFINES_SVH

// same-cycle implication, reset masked
`define FRQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define FRQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/frq_pkg.sv =====
// ---------------------------------------------------------------------------
// frq_pkg
// types and constants shared by the frame ring queue modules
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package frq_pkg;

    localparam int SLOTS       = 16;
    localparam int FRAME_BYTES = 64;
    // one spare buffer beyond the ring serves as the staging buffer
    localparam int BUFS        = SLOTS + 1;
    localparam int BUF_W       = $clog2(BUFS);
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int LEN_W       = 7;
    localparam int POS_W       = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int MEM_DEPTH   = BUFS * FRAME_BYTES;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int CFG_W       = 5;
    localparam int CFG_RESET   = 16;
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);

    typedef enum logic [2:0] {
        ST_READ_OK   = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_STORED    = 3'd2,
        ST_OVERWRITE = 3'd3,
        ST_DROPPED   = 3'd4
    } status_t;

    typedef enum logic {
        CMD_RESULT = 1'b0,
        CMD_READ   = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        logic             action;
        logic [7:0]       data_byte;
        logic             frame_end;
        logic [LEN_W-1:0] read_limit;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             run_last;
        logic [LEN_W-1:0] frame_length;
        status_t          status;
    } out_item_t;

    typedef struct packed {
        logic [BUF_W-1:0] bid;
        logic [LEN_W-1:0] len;
    } slot_entry_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [BUF_W-1:0] bid;
        logic [LEN_W-1:0] count;
        logic [LEN_W-1:0] len;
        status_t          status;
    } cmd_t;

    typedef struct packed {
        logic             en;
        logic [BUF_W-1:0] bid;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
    } mem_wr_t;

    typedef struct packed {
        logic             active;
        logic [BUF_W-1:0] bid;
    } rd_busy_t;

endpackage

`default_nettype wire

// ===== hdl/frq_front.sv =====
// ---------------------------------------------------------------------------
// frq_front
// accepts words, stages frame bytes, keeps ring bookkeeping, issues commands
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frq_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [frq_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire frq_pkg::in_item_t            s_data,
    output logic                              push,
    output frq_pkg::cmd_t                     push_cmd,
    input  wire logic                         q_full,
    input  wire logic                         q_hit,
    output logic [frq_pkg::BUF_W-1:0]         chk_bid,
    input  wire frq_pkg::rd_busy_t            busy,
    output frq_pkg::mem_wr_t                  wr
);

    logic [frq_pkg::CFG_W-1:0]  slots_reg, slots_next;
    logic [frq_pkg::SLOT_W-1:0] head_reg, head_next;
    logic [frq_pkg::CNT_W-1:0]  held_reg, held_next;
    logic [frq_pkg::LEN_W-1:0]  fill_reg, fill_next;
    logic                       too_long_reg, too_long_next;
    logic [frq_pkg::BUF_W-1:0]  stage_reg, stage_next;
    frq_pkg::slot_entry_t       map_reg  [frq_pkg::SLOTS];
    frq_pkg::slot_entry_t       map_next [frq_pkg::SLOTS];

    logic [frq_pkg::CNT_W-1:0]  ring_n;
    logic [frq_pkg::CNT_W:0]    tail_sum;
    logic [frq_pkg::SLOT_W-1:0] tail_slot;
    logic [frq_pkg::CNT_W-1:0]  head_plus;
    logic [frq_pkg::SLOT_W-1:0] head_wrap;
    logic [frq_pkg::SLOT_W-1:0] sel_slot;
    frq_pkg::slot_entry_t       entry;
    logic                       hazard;
    logic                       fire;
    logic                       cfg_fire;
    logic                       room;
    logic [frq_pkg::LEN_W-1:0]  new_len;
    logic                       drop;
    logic [frq_pkg::LEN_W-1:0]  limit_sat;
    logic [frq_pkg::LEN_W-1:0]  count;

    // ring size clamps to 1..SLOTS
    always_comb begin
        if (slots_reg == '0) begin
            ring_n = frq_pkg::CNT_W'(1);
        end else if (int'(slots_reg) > frq_pkg::SLOTS) begin
            ring_n = frq_pkg::CNT_W'(frq_pkg::SLOTS);
        end else begin
            ring_n = frq_pkg::CNT_W'(slots_reg);
        end
    end

    // head + held stays below twice the ring size, one subtract wraps it
    assign tail_sum  = {1'b0, frq_pkg::CNT_W'(head_reg)} + {1'b0, held_reg};
    assign tail_slot = (tail_sum >= {1'b0, ring_n})
                     ? frq_pkg::SLOT_W'(tail_sum - {1'b0, ring_n})
                     : frq_pkg::SLOT_W'(tail_sum);
    assign head_plus = frq_pkg::CNT_W'(head_reg) + frq_pkg::CNT_W'(1);
    assign head_wrap = (head_plus == ring_n) ? '0 : frq_pkg::SLOT_W'(head_plus);

    assign sel_slot = s_data.action ? head_reg : tail_slot;
    assign entry    = map_reg[sel_slot];

    // staging buffer may still be streamed by an earlier read
    assign chk_bid   = stage_reg;
    assign hazard    = q_hit || (busy.active && (busy.bid == stage_reg));
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_ready   = !q_full && !hazard && !cfg_valid;
    assign fire      = s_valid && s_ready;

    assign room      = fill_reg < frq_pkg::LEN_W'(frq_pkg::FRAME_BYTES);
    assign new_len   = room ? fill_reg + frq_pkg::LEN_W'(1) : fill_reg;
    assign drop      = too_long_reg || !room;
    assign limit_sat = (s_data.read_limit > frq_pkg::LEN_W'(frq_pkg::FRAME_BYTES))
                     ? frq_pkg::LEN_W'(frq_pkg::FRAME_BYTES) : s_data.read_limit;
    assign count     = (limit_sat < entry.len) ? limit_sat : entry.len;

    always_comb begin
        slots_next    = slots_reg;
        head_next     = head_reg;
        held_next     = held_reg;
        fill_next     = fill_reg;
        too_long_next = too_long_reg;
        stage_next    = stage_reg;
        map_next      = map_reg;
        push          = 1'b0;
        push_cmd      = '{kind: frq_pkg::CMD_RESULT, bid: '0, count: '0, len: '0,
                          status: frq_pkg::ST_READ_OK};
        wr.en         = fire && !s_data.action && room;
        wr.bid        = stage_reg;
        wr.pos        = frq_pkg::POS_W'(fill_reg);
        wr.data       = s_data.data_byte;

        if (cfg_fire) begin
            slots_next    = cfg_data;
            head_next     = '0;
            held_next     = '0;
            fill_next     = '0;
            too_long_next = 1'b0;
        end else if (fire) begin
            if (!s_data.action) begin
                if (room) begin
                    fill_next = new_len;
                end else begin
                    too_long_next = 1'b1;
                end
                if (s_data.frame_end) begin
                    fill_next     = '0;
                    too_long_next = 1'b0;
                    push          = 1'b1;
                    if (drop) begin
                        push_cmd.status = frq_pkg::ST_DROPPED;
                    end else begin
                        // commit by swapping the staging buffer into the tail slot
                        map_next[tail_slot] = '{bid: stage_reg, len: new_len};
                        stage_next          = entry.bid;
                        push_cmd.len        = new_len;
                        if (held_reg >= ring_n) begin
                            head_next       = head_wrap;
                            push_cmd.status = frq_pkg::ST_OVERWRITE;
                        end else begin
                            held_next       = held_reg + frq_pkg::CNT_W'(1);
                            push_cmd.status = frq_pkg::ST_STORED;
                        end
                    end
                end
            end else begin
                push = 1'b1;
                if (held_reg == '0) begin
                    push_cmd.status = frq_pkg::ST_EMPTY;
                end else begin
                    head_next    = head_wrap;
                    held_next    = held_reg - frq_pkg::CNT_W'(1);
                    push_cmd.len = entry.len;
                    if (count != '0) begin
                        push_cmd.kind  = frq_pkg::CMD_READ;
                        push_cmd.bid   = entry.bid;
                        push_cmd.count = count;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg    <= frq_pkg::CFG_W'(frq_pkg::CFG_RESET);
            head_reg     <= '0;
            held_reg     <= '0;
            fill_reg     <= '0;
            too_long_reg <= 1'b0;
            stage_reg    <= frq_pkg::BUF_W'(frq_pkg::SLOTS);
            for (int i = 0; i < frq_pkg::SLOTS; i++) begin
                map_reg[i] <= '{bid: frq_pkg::BUF_W'(i), len: '0};
            end
        end else begin
            slots_reg    <= slots_next;
            head_reg     <= head_next;
            held_reg     <= held_next;
            fill_reg     <= fill_next;
            too_long_reg <= too_long_next;
            stage_reg    <= stage_next;
            map_reg      <= map_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/frq_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// frq_cmd_fifo
// short command queue between front and back, with a buffer-in-use lookup
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frq_cmd_fifo (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         push,
    input  wire frq_pkg::cmd_t                push_cmd,
    output logic                              full,
    input  wire logic                         pop,
    output logic                              empty,
    output frq_pkg::cmd_t                     pop_cmd,
    input  wire logic [frq_pkg::BUF_W-1:0]    chk_bid,
    output logic                              hit
);

    frq_pkg::cmd_t               ent_reg [frq_pkg::CMDQ_DEPTH];
    logic [frq_pkg::CMDQ_DEPTH-1:0] vld_reg, vld_next;
    logic [frq_pkg::CMDQ_AW-1:0] wr_ptr_reg;
    logic [frq_pkg::CMDQ_AW-1:0] rd_ptr_reg;

    assign full    = vld_reg[wr_ptr_reg];
    assign empty   = !vld_reg[rd_ptr_reg];
    assign pop_cmd = ent_reg[rd_ptr_reg];

    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < frq_pkg::CMDQ_DEPTH; i++) begin
            if (vld_reg[i] && (ent_reg[i].kind == frq_pkg::CMD_READ)
                    && (ent_reg[i].bid == chk_bid)) begin
                hit = 1'b1;
            end
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (pop) begin
            vld_next[rd_ptr_reg] = 1'b0;
        end
        if (push) begin
            vld_next[wr_ptr_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            vld_reg <= vld_next;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + frq_pkg::CMDQ_AW'(1);
            end
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + frq_pkg::CMDQ_AW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/frq_back.sv =====
// ---------------------------------------------------------------------------
// frq_back
// frame byte memory and result sequencer with a registered output word
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frq_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire frq_pkg::mem_wr_t   wr,
    input  wire logic               q_empty,
    input  wire frq_pkg::cmd_t      q_cmd,
    output logic                    q_pop,
    output frq_pkg::rd_busy_t       busy,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output frq_pkg::out_item_t      m_data
);

    logic [7:0] mem [frq_pkg::MEM_DEPTH];

    logic                       active_reg, active_next;
    logic [frq_pkg::BUF_W-1:0]  bid_reg, bid_next;
    logic [frq_pkg::LEN_W-1:0]  cnt_reg, cnt_next;
    logic [frq_pkg::LEN_W-1:0]  idx_reg, idx_next;
    logic [frq_pkg::LEN_W-1:0]  len_reg, len_next;
    logic                       m_valid_reg;
    logic                       bv_reg, bv_next;
    logic                       last_reg, last_next;
    logic [frq_pkg::LEN_W-1:0]  flen_reg, flen_next;
    frq_pkg::status_t           status_reg, status_next;
    logic [7:0]                 rd_data_reg;

    logic                       can_issue;
    logic                       issue;
    logic                       rd_en;
    logic                       byte_last;
    logic [frq_pkg::ADDR_W-1:0] rd_addr;
    logic [frq_pkg::ADDR_W-1:0] wr_addr;

    assign can_issue = !m_valid_reg || m_ready;
    assign byte_last = (idx_reg + frq_pkg::LEN_W'(1)) == cnt_reg;
    assign rd_addr   = frq_pkg::ADDR_W'(bid_reg) * frq_pkg::ADDR_W'(frq_pkg::FRAME_BYTES)
                     + frq_pkg::ADDR_W'(idx_reg[frq_pkg::POS_W-1:0]);
    assign wr_addr   = frq_pkg::ADDR_W'(wr.bid) * frq_pkg::ADDR_W'(frq_pkg::FRAME_BYTES)
                     + frq_pkg::ADDR_W'(wr.pos);

    always_comb begin
        active_next = active_reg;
        bid_next    = bid_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        bv_next     = bv_reg;
        last_next   = last_reg;
        flen_next   = flen_reg;
        status_next = status_reg;
        issue       = 1'b0;
        rd_en       = 1'b0;
        q_pop       = 1'b0;

        if (active_reg) begin
            if (can_issue) begin
                issue       = 1'b1;
                rd_en       = 1'b1;
                bv_next     = 1'b1;
                last_next   = byte_last;
                flen_next   = len_reg;
                status_next = frq_pkg::ST_READ_OK;
                idx_next    = idx_reg + frq_pkg::LEN_W'(1);
                if (byte_last) begin
                    active_next = 1'b0;
                end
            end
        end else if (!q_empty) begin
            if (q_cmd.kind == frq_pkg::CMD_READ) begin
                // load the read, bytes stream once it is active and the output can take them
                q_pop       = 1'b1;
                active_next = 1'b1;
                bid_next    = q_cmd.bid;
                cnt_next    = q_cmd.count;
                len_next    = q_cmd.len;
                idx_next    = '0;
            end else if (can_issue) begin
                q_pop       = 1'b1;
                issue       = 1'b1;
                bv_next     = 1'b0;
                last_next   = 1'b1;
                flen_next   = q_cmd.len;
                status_next = q_cmd.status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        bid_reg <= bid_next;
        cnt_reg <= cnt_next;
        idx_reg <= idx_next;
        len_reg <= len_next;
        if (issue) begin
            bv_reg     <= bv_next;
            last_reg   <= last_next;
            flen_reg   <= flen_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            if (issue) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign busy.active         = active_reg;
    assign busy.bid            = bid_reg;
    assign m_valid             = m_valid_reg;
    assign m_data.out_byte     = bv_reg ? rd_data_reg : 8'd0;
    assign m_data.byte_valid   = bv_reg;
    assign m_data.run_last     = last_reg;
    assign m_data.frame_length = flen_reg;
    assign m_data.status       = status_reg;

endmodule

`default_nettype wire

// ===== hdl/frame_ring_queue_overwrite.sv =====
// ---------------------------------------------------------------------------
// frame_ring_queue_overwrite
// circular queue of byte frames in fixed slots, oldest frame overwritten
// ---------------------------------------------------------------------------
// A write word puts its byte straight into a spare staging buffer, and the
// frame_end word commits the frame by swapping that buffer into the tail
// slot, so a commit, a drop, an empty read or a zero-limit read gives one
// result word. A read of N bytes gives N result words, one per cycle while
// the output is not stalled, from the single read port of the frame memory,
// after the back end has loaded the command; N is the read limit cut at the
// frame length and at 64. Words that make results pass through a two-entry
// command queue, so plain frame bytes keep flowing while a read streams and
// up to two result-making words can wait behind it. The input waits while
// the queue is full, while a slot count write is offered, or while a queued
// or running read still streams the buffer that the next frame bytes land in.
// Writing the slot count empties the queue and is meant for an idle block.
`timescale 1ns / 1ps
`default_nettype none

module frame_ring_queue_overwrite (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [frq_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire frq_pkg::in_item_t            s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output frq_pkg::out_item_t                m_data
);

    logic                       push;
    frq_pkg::cmd_t              push_cmd;
    logic                       q_full;
    logic                       q_hit;
    logic [frq_pkg::BUF_W-1:0]  chk_bid;
    logic                       q_pop;
    logic                       q_empty;
    frq_pkg::cmd_t              q_cmd;
    frq_pkg::rd_busy_t          busy;
    frq_pkg::mem_wr_t           wr;

    frq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_cmd  (push_cmd),
        .q_full    (q_full),
        .q_hit     (q_hit),
        .chk_bid   (chk_bid),
        .busy      (busy),
        .wr        (wr)
    );

    frq_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_cmd  (q_cmd),
        .chk_bid  (chk_bid),
        .hit      (q_hit)
    );

    frq_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .q_empty (q_empty),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .busy    (busy),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== hdl/frq_checker.sv =====
// ---------------------------------------------------------------------------
// frq_checker
// port-level checks on the frame ring queue result channel
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "frame_ring_queue_overwrite_defines.svh"

module frq_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         m_valid,
    input  wire logic                         m_ready,
    input  wire frq_pkg::out_item_t           m_data
);

    // stalled result word holds
    `FRQ_ASSERT_NXT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready, m_valid && $stable(m_data),
        "stalled result word changed")

    // a word without a byte always closes its run
    `FRQ_ASSERT_IMP(a_nonbyte_last, aclk, aresetn,
        m_valid && !m_data.byte_valid, m_data.run_last,
        "word without byte not marked last")

    // bytes only come from reads
    `FRQ_ASSERT_IMP(a_byte_status, aclk, aresetn,
        m_valid && m_data.byte_valid, m_data.status == frq_pkg::ST_READ_OK,
        "byte word with non-read status")

    // empty reads and drops carry no length and no byte
    `FRQ_ASSERT_IMP(a_nolen, aclk, aresetn,
        m_valid && (m_data.status == frq_pkg::ST_EMPTY
                    || m_data.status == frq_pkg::ST_DROPPED),
        m_data.frame_length == '0 && !m_data.byte_valid,
        "empty or drop word with length or byte")

endmodule

bind frame_ring_queue_overwrite frq_checker u_frq_checker (.*);

`default_nettype wire

// ===== tb/sv/frq_frame_checker.sv =====
// ---------------------------------------------------------------------------
// frame ring queue checker
// watches the config, input and result channels, keeps its own copy of the
// slot ring, predicts every result word and compares each accepted one
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module frq_frame_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [frq_pkg::CFG_W-1:0] cfg_data,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  frq_pkg::in_item_t         s_data,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  frq_pkg::out_item_t        m_data,
    output int                        mismatches,
    output int                        words_due
);
    import frq_pkg::*;

    localparam logic WORD_READ = 1'b1;

    logic [7:0]       ring_bytes [SLOTS][FRAME_BYTES];
    logic [LEN_W-1:0] ring_len [SLOTS];
    logic [7:0]       gather [FRAME_BYTES];
    int unsigned      head;
    int unsigned      held;
    int unsigned      fill;
    bit               overflow;
    logic [CFG_W-1:0] slots_cfg;
    out_item_t        due_words [$];
    int               fails = 0;
    int               pending = 0;

    assign mismatches = fails;
    assign words_due  = pending;

    function automatic void add_result(input logic [7:0] b, input logic v, input logic l,
                                       input logic [LEN_W-1:0] len, input status_t st);
        out_item_t r;
        r.out_byte     = b;
        r.byte_valid   = v;
        r.run_last     = l;
        r.frame_length = len;
        r.status       = st;
        due_words.push_back(r);
    endfunction

    // one accepted input word against the ring copy
    function automatic void step_ring(input in_item_t w);
        int unsigned      n;
        int unsigned      tail;
        int unsigned      lim;
        int unsigned      cnt;
        logic [LEN_W-1:0] len;
        status_t          st;
        n = (slots_cfg == 0) ? 1 : ((slots_cfg > SLOTS) ? SLOTS : slots_cfg);
        if (w.action != WORD_READ) begin
            if (fill < FRAME_BYTES) begin
                gather[fill] = w.data_byte;
                fill++;
            end else begin
                overflow = 1'b1;
            end
            if (w.frame_end) begin
                if (overflow) begin
                    add_result(8'h00, 1'b0, 1'b1, '0, ST_DROPPED);
                end else begin
                    tail = (head + held) % n;
                    for (int i = 0; i < fill; i++)
                        ring_bytes[tail][i] = gather[i];
                    ring_len[tail] = fill;
                    if (held >= n) begin
                        head = (head + 1) % n;
                        st   = ST_OVERWRITE;
                    end else begin
                        held++;
                        st = ST_STORED;
                    end
                    add_result(8'h00, 1'b0, 1'b1, fill, st);
                end
                fill     = 0;
                overflow = 1'b0;
            end
        end else if (held == 0) begin
            add_result(8'h00, 1'b0, 1'b1, '0, ST_EMPTY);
        end else begin
            len = ring_len[head];
            lim = (w.read_limit > FRAME_BYTES) ? FRAME_BYTES : w.read_limit;
            cnt = (lim < len) ? lim : len;
            if (cnt == 0)
                add_result(8'h00, 1'b0, 1'b1, len, ST_READ_OK);
            for (int i = 0; i < cnt; i++)
                add_result(ring_bytes[head][i], 1'b1, (i + 1 == cnt), len, ST_READ_OK);
            head = (head + 1) % n;
            held--;
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            slots_cfg = CFG_RESET;
            head      = 0;
            held      = 0;
            fill      = 0;
            overflow  = 1'b0;
            due_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                // a slot count write empties the ring and the partial frame
                slots_cfg = cfg_data;
                head      = 0;
                held      = 0;
                fill      = 0;
                overflow  = 1'b0;
            end
            if (s_valid && s_ready)
                step_ring(s_data);
            if (m_valid && m_ready) begin
                if (due_words.size() == 0) begin
                    $error("result word with nothing expected: %h", m_data);
                    fails++;
                end else begin
                    want = due_words.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h",
                               want.out_byte, m_data.out_byte);
                        fails++;
                    end
                    if (m_data.byte_valid !== want.byte_valid) begin
                        $error("byte_valid: expected %0b, got %0b",
                               want.byte_valid, m_data.byte_valid);
                        fails++;
                    end
                    if (m_data.run_last !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b",
                               want.run_last, m_data.run_last);
                        fails++;
                    end
                    if (m_data.frame_length !== want.frame_length) begin
                        $error("frame_length: expected %0d, got %0d",
                               want.frame_length, m_data.frame_length);
                        fails++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, m_data.status);
                        fails++;
                    end
                end
            end
        end
        pending = due_words.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// frame ring queue testbench
// drives directed and random frame writes and reads through several slot
// counts, with random gaps on both channels; the checker scores the results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import frq_pkg::*;

    localparam logic WORD_WRITE     = 1'b0;
    localparam logic WORD_READ      = 1'b1;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   DRAIN_CYCLES   = 10;
    localparam int   PHASE_WORDS    = 28;

    logic             aclk;
    logic             aresetn;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;
    int               mismatches;
    int               words_due;
    int               quiet_cycles;
    int               words_sent;
    bit               calm;

    frame_ring_queue_overwrite dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    frq_frame_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .words_due  (words_due)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [LEN_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 4);
        if (r < 80)
            return $urandom_range(0, FRAME_BYTES);
        return $urandom_range(0, 127);
    endfunction

    function automatic in_item_t byte_word(input logic [7:0] d, input logic last);
        in_item_t w;
        w.action     = WORD_WRITE;
        w.data_byte  = d;
        w.frame_end  = last;
        w.read_limit = $urandom_range(0, 127);
        return w;
    endfunction

    function automatic in_item_t read_req(input logic [LEN_W-1:0] lim);
        in_item_t w;
        w.action     = WORD_READ;
        w.data_byte  = $urandom_range(0, 255);
        w.frame_end  = $urandom_range(0, 1);
        w.read_limit = lim;
        return w;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input in_item_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (s_ready !== 1'b1);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send_frame(input int len, input bit mix_reads);
        for (int i = 1; i <= len; i++) begin
            if (mix_reads && $urandom_range(0, 11) == 0)
                send_word(read_req(pick_limit()));
            send_word(byte_word($urandom_range(0, 255), i == len));
        end
    endtask

    // only with the block idle: all results in, then a wait to settle
    task automatic set_slots(input logic [CFG_W-1:0] v);
        s_valid <= 1'b0;
        wait (words_due == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    initial begin
        calm = 1'b0;
        forever begin
            repeat ($urandom_range(100, 400)) @(posedge aclk);
            calm <= ~calm;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int                       slots;
        int                       write_pct;
        int                       max_len;
        int                       target;
        int                       r;
        logic [$bits(in_item_t)-1:0] raw;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        quiet_cycles = 0;
        words_sent   = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, ring at its reset size
        send_word(read_req(7'd5));            // empty queue
        send_word(byte_word(8'h00, 1'b1));    // one-byte frame
        send_word(byte_word(8'hFF, 1'b0));
        send_word(byte_word(8'hA5, 1'b0));
        send_word(byte_word(8'h5A, 1'b1));
        send_word(read_req(7'd0));            // zero limit still frees the slot
        send_word(read_req(7'd127));          // saturated limit
        send_word(byte_word(8'h11, 1'b0));
        send_word(read_req(7'd64));           // read while a frame is gathering
        send_word(byte_word(8'h22, 1'b0));
        send_word(byte_word(8'h33, 1'b1));
        send_word(read_req(7'd2));            // cut short
        send_word(read_req(7'd1));
        set_slots(5'd1);
        send_word(byte_word(8'h01, 1'b1));
        send_word(byte_word(8'h02, 1'b0));
        send_word(byte_word(8'h03, 1'b1));    // overwrites the only slot
        send_word(read_req(7'd64));
        send_word(read_req(7'd64));

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    slots = 16; write_pct = 55; max_len = 8;
                end
                1: begin
                    slots = 2; write_pct = 60; max_len = 6;
                end
                2: begin
                    slots = 0; write_pct = 50; max_len = 4;
                end
                3: begin
                    // write heavy with short frames so a full ring overwrites
                    slots = 31; write_pct = 92; max_len = 2;
                end
                4: begin
                    slots = $urandom_range(3, 15); write_pct = 55; max_len = 10;
                end
                default: begin
                    slots = 1; write_pct = 45; max_len = 20;
                end
            endcase
            set_slots(slots);
            if (p == 0) begin
                send_frame(FRAME_BYTES, 1'b0);
                send_word(read_req(7'd100));
            end
            if (p == 1)
                send_frame(FRAME_BYTES + 2, 1'b0);   // too long, dropped
            target = words_sent + PHASE_WORDS;
            while (words_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < write_pct) begin
                    send_frame($urandom_range(1, max_len), 1'b1);
                end else if (r < 93) begin
                    send_word(read_req(pick_limit()));
                end else begin
                    raw = $urandom;
                    send_word(raw);
                end
            end
        end

        s_valid <= 1'b0;
        wait (words_due == 0);
        repeat (20) @(negedge aclk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
